### hw/rtl/meter_modbus_request_and_reply_decode_unit_defines.svh
// assertion macros used by the meter modbus decode unit back end
`ifndef METER_MODBUS_REQUEST_AND_REPLY_DECODE_UNIT_DEFINES_SVH
`define METER_MODBUS_REQUEST_AND_REPLY_DECODE_UNIT_DEFINES_SVH

// condition that holds at every edge out of reset
`define MMRD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mmrd assertion failed");

// same-cycle implication
`define MMRD_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmrd assertion failed");

// next-cycle implication
`define MMRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmrd assertion failed");

`endif

### hw/rtl/mmrd_pkg.sv
// types, constants and crc function of the meter modbus decode unit
package mmrd_pkg;

	// reply store sizing
	localparam int RX_BUFFER_BYTES = 32;
	localparam int STORE_BYTES     = 15;
	localparam int IDX_W           = $clog2(RX_BUFFER_BYTES + 1);

	// protocol constants
	localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd248;
	localparam logic [7:0]  FUNC_READ_INPUT  = 8'h04;
	localparam logic [7:0]  FUNC_RESET_ENERGY = 8'h42;
	localparam logic [7:0]  READ_REG_COUNT   = 8'h08;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam logic [2:0]  READ_MSG_LEN     = 3'd6;
	localparam logic [2:0]  RESET_MSG_LEN    = 3'd4;

	// func codes on the input channel
	localparam logic [1:0] FUNC_CODE_READ  = 2'd0;
	localparam logic [1:0] FUNC_CODE_RESET = 2'd1;
	localparam logic [1:0] FUNC_CODE_BYTE  = 2'd2;

	// classified operation
	typedef enum logic [1:0] {
		OP_READ,
		OP_RESET,
		OP_BYTE
	} mmrd_op_t;

	// one queued item
	typedef struct packed {
		mmrd_op_t   op;
		logic [7:0] rx_byte;
		logic       rx_last;
	} mmrd_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} mmrd_qstat_t;

	// one crc16 byte update, reflected polynomial
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### hw/rtl/mmrd_if.sv
// channel interfaces of the meter modbus decode unit
interface mmrd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, func, rx_byte, rx_last, input ready);
	modport sink (input valid, func, rx_byte, rx_last, output ready);
endinterface

interface mmrd_rsp_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        tx_last;
	logic        frame_done;
	logic        frame_match;
	logic [15:0] voltage_raw;
	logic [15:0] current_raw;
	logic [31:0] power_raw;
	logic [31:0] energy_raw;

	modport source (output valid, tx_valid, tx_byte, tx_last, frame_done, frame_match,
		voltage_raw, current_raw, power_raw, energy_raw, input ready);
	modport sink (input valid, tx_valid, tx_byte, tx_last, frame_done, frame_match,
		voltage_raw, current_raw, power_raw, energy_raw, output ready);
endinterface

### hw/rtl/mmrd_front.sv
// front end: accepts input items and classifies them for the queue
module mmrd_front (
	mmrd_cmd_if.sink           cmd,
	input  mmrd_pkg::mmrd_qstat_t qstat,
	output logic               push,
	output mmrd_pkg::mmrd_entry_t entry
);

	// accept whenever the queue has room
	assign cmd.ready = !qstat.full;

	// classify; unused func code is dropped
	always_comb begin
		entry.rx_byte = cmd.rx_byte;
		entry.rx_last = cmd.rx_last;
		entry.op      = mmrd_pkg::OP_BYTE;
		push          = 1'b0;
		unique case (cmd.func)
			mmrd_pkg::FUNC_CODE_READ: begin
				entry.op = mmrd_pkg::OP_READ;
				push     = cmd.valid && !qstat.full;
			end
			mmrd_pkg::FUNC_CODE_RESET: begin
				entry.op = mmrd_pkg::OP_RESET;
				push     = cmd.valid && !qstat.full;
			end
			mmrd_pkg::FUNC_CODE_BYTE: begin
				entry.op = mmrd_pkg::OP_BYTE;
				push     = cmd.valid && !qstat.full;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/mmrd_fifo.sv
// two-entry queue between front and back
module mmrd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mmrd_pkg::mmrd_entry_t push_entry,
	input  logic                  pop,
	output mmrd_pkg::mmrd_entry_t head,
	output mmrd_pkg::mmrd_qstat_t qstat
);

	mmrd_pkg::mmrd_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head           = slot_q[rd_ptr_q];
	assign qstat.full     = (cnt_q == 2'd2);
	assign qstat.nonempty = (cnt_q != 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/mmrd_back.sv
// back end: request byte sequencer with crc, reply store and frame decode
`include "meter_modbus_request_and_reply_decode_unit_defines.svh"

module mmrd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            slave_address,
	input  mmrd_pkg::mmrd_entry_t head,
	input  mmrd_pkg::mmrd_qstat_t qstat,
	output logic                  pop,
	mmrd_rsp_if.source            rsp
);

	logic [2:0]  seq_q;
	logic [15:0] crc_q;
	logic [mmrd_pkg::IDX_W-1:0] idx_q;
	logic [7:0]  store_q [mmrd_pkg::STORE_BYTES];
	logic [7:0]  st [mmrd_pkg::STORE_BYTES];

	logic        out_valid_q;
	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;
	logic        tx_last_q;
	logic        frame_done_q;
	logic        frame_match_q;
	logic [15:0] voltage_q;
	logic [15:0] current_q;
	logic [31:0] power_q;
	logic [31:0] energy_q;

	logic        slot_free;
	logic        is_req;
	logic [2:0]  msg_len;
	logic [7:0]  msg_byte;
	logic [15:0] crc_in;
	logic [15:0] crc_next;
	logic [7:0]  tx_byte_d;
	logic        req_last;
	logic        req_emit;
	logic        byte_go;
	logic        frame_end;
	logic        store_wr;
	logic        idx_inc;
	logic        clear_store;
	logic        match;

	assign slot_free = !out_valid_q || rsp.ready;
	assign is_req    = (head.op == mmrd_pkg::OP_READ) || (head.op == mmrd_pkg::OP_RESET);
	assign msg_len   = (head.op == mmrd_pkg::OP_READ) ? mmrd_pkg::READ_MSG_LEN
		: mmrd_pkg::RESET_MSG_LEN;

	// message byte for the current sequence step
	always_comb begin
		msg_byte = 8'h00;
		if (head.op == mmrd_pkg::OP_READ) begin
			unique case (seq_q)
				3'd0:    msg_byte = slave_address;
				3'd1:    msg_byte = mmrd_pkg::FUNC_READ_INPUT;
				3'd5:    msg_byte = mmrd_pkg::READ_REG_COUNT;
				default: msg_byte = 8'h00;
			endcase
		end else begin
			unique case (seq_q)
				3'd0:    msg_byte = slave_address;
				3'd1:    msg_byte = mmrd_pkg::FUNC_RESET_ENERGY;
				default: msg_byte = 8'h00;
			endcase
		end
	end

	// running crc, seeded on the first byte
	assign crc_in   = (seq_q == 3'd0) ? mmrd_pkg::CRC_INIT : crc_q;
	assign crc_next = mmrd_pkg::crc16_update(crc_in, msg_byte);

	// byte on the wire: message, then crc low, then crc high
	always_comb begin
		if (seq_q < msg_len) begin
			tx_byte_d = msg_byte;
		end else if (seq_q == msg_len) begin
			tx_byte_d = crc_in[7:0];
		end else begin
			tx_byte_d = crc_in[15:8];
		end
	end

	assign req_last  = (seq_q == (msg_len + 3'd1));
	assign req_emit  = qstat.nonempty && is_req && slot_free;
	assign byte_go   = qstat.nonempty && (head.op == mmrd_pkg::OP_BYTE)
		&& (!head.rx_last || slot_free);
	assign frame_end = byte_go && head.rx_last;
	assign pop       = (req_emit && req_last) || byte_go;
	assign clear_store = (req_emit && req_last) || frame_end;

	// reply byte capture with saturating index
	assign idx_inc  = byte_go && (idx_q < mmrd_pkg::IDX_W'(mmrd_pkg::RX_BUFFER_BYTES));
	assign store_wr = byte_go && (idx_q < mmrd_pkg::IDX_W'(mmrd_pkg::STORE_BYTES));

	// store contents including the byte being written
	always_comb begin
		for (int i = 0; i < mmrd_pkg::STORE_BYTES; i++) begin
			st[i] = (store_wr && (idx_q == mmrd_pkg::IDX_W'(i))) ? head.rx_byte : store_q[i];
		end
	end

	assign match = (st[0] == slave_address) && (st[1] == mmrd_pkg::FUNC_READ_INPUT);

	// sequencer, crc and reply store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= 3'd0;
			crc_q <= mmrd_pkg::CRC_INIT;
			idx_q <= '0;
			for (int i = 0; i < mmrd_pkg::STORE_BYTES; i++) begin
				store_q[i] <= 8'h00;
			end
		end else begin
			if (req_emit) begin
				seq_q <= req_last ? 3'd0 : (seq_q + 3'd1);
				if (seq_q < msg_len) begin
					crc_q <= crc_next;
				end
			end
			if (clear_store) begin
				idx_q <= '0;
				for (int i = 0; i < mmrd_pkg::STORE_BYTES; i++) begin
					store_q[i] <= 8'h00;
				end
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + mmrd_pkg::IDX_W'(1);
				end
				for (int i = 0; i < mmrd_pkg::STORE_BYTES; i++) begin
					store_q[i] <= st[i];
				end
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_emit || frame_end) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (req_emit) begin
			tx_valid_q    <= 1'b1;
			tx_byte_q     <= tx_byte_d;
			tx_last_q     <= req_last;
			frame_done_q  <= 1'b0;
			frame_match_q <= 1'b0;
			voltage_q     <= 16'h0000;
			current_q     <= 16'h0000;
			power_q       <= 32'h0000_0000;
			energy_q      <= 32'h0000_0000;
		end else if (frame_end) begin
			tx_valid_q    <= 1'b0;
			tx_byte_q     <= 8'h00;
			tx_last_q     <= 1'b0;
			frame_done_q  <= 1'b1;
			frame_match_q <= match;
			voltage_q     <= match ? {st[3], st[4]} : 16'h0000;
			current_q     <= match ? {st[5], st[6]} : 16'h0000;
			power_q       <= match ? {st[9], st[10], st[7], st[8]} : 32'h0000_0000;
			energy_q      <= match ? {st[13], st[14], st[11], st[12]} : 32'h0000_0000;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.tx_valid    = tx_valid_q;
	assign rsp.tx_byte     = tx_byte_q;
	assign rsp.tx_last     = tx_last_q;
	assign rsp.frame_done  = frame_done_q;
	assign rsp.frame_match = frame_match_q;
	assign rsp.voltage_raw = voltage_q;
	assign rsp.current_raw = current_q;
	assign rsp.power_raw   = power_q;
	assign rsp.energy_raw  = energy_q;

	// checks
	`MMRD_ASSERT_ALWAYS(a_idx_saturates, idx_q <= mmrd_pkg::IDX_W'(mmrd_pkg::RX_BUFFER_BYTES))
	`MMRD_ASSERT_IMPLIES(a_reset_seq_bound, qstat.nonempty && head.op == mmrd_pkg::OP_RESET, seq_q <= 3'd5)
	`MMRD_ASSERT_NEXT(a_stall_holds_seq, out_valid_q && !rsp.ready, $stable(seq_q))
	`MMRD_ASSERT_IMPLIES(a_match_in_frame, out_valid_q && frame_match_q, frame_done_q && !tx_valid_q)

endmodule

### hw/rtl/meter_modbus_request_and_reply_decode_unit.sv
// top level of the meter modbus request builder and reply decoder
//
// cmd channel: one item per func code; func 0 builds a read input registers
// request, func 1 an energy reset request, func 2 delivers one reply byte
// (rx_last closes the frame), func 3 is dropped without a result.
// rsp channel: a request gives one item per transmitted byte (6 or 8, crc
// low byte first, tx_last on the final one); a closing reply byte gives one
// decoded frame item with the address/function check and raw readings.
// cfg_we/cfg_wdata write the slave address; change it only while idle.
// an item reaches the two-entry queue at accept; its first result is loaded
// into the output register once it is at the queue head and the register is free.
// a request occupies the back-end byte sequencer for its 6 or 8 bytes, one
// byte a cycle unless rsp stalls; a closing reply byte also waits for rsp.
// the crc is folded in one byte per cycle as the bytes go out.
// a stalled rsp holds its item; the sequencer halts and cmd keeps taking
// items until the queue fills.
// reset: slave address returns to 248, the reply store and index clear,
// queue and output register empty.
module meter_modbus_request_and_reply_decode_unit (
	input  logic       clk,
	input  logic       arst_n,
	mmrd_cmd_if.sink   cmd,
	mmrd_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [7:0]            slave_address_q;
	logic                  push;
	logic                  pop;
	mmrd_pkg::mmrd_entry_t push_entry;
	mmrd_pkg::mmrd_entry_t head;
	mmrd_pkg::mmrd_qstat_t qstat;

	// slave address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mmrd_pkg::SLAVE_ADDR_RESET;
		end else if (cfg_we) begin
			slave_address_q <= cfg_wdata;
		end
	end

	// front end
	mmrd_front u_front (
		.cmd   (cmd),
		.qstat (qstat),
		.push  (push),
		.entry (push_entry)
	);

	// queue
	mmrd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back end
	mmrd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_address_q),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.rsp           (rsp)
	);

endmodule
